// ===== src/nll_pkg.sv =====
package nll_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
	localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
	localparam logic [7:0] CH_LOW_E = 8'h65;  // 'e'
	localparam logic [7:0] CH_UP_E  = 8'h45;  // 'E'
	localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'

	typedef enum logic [2:0] {
		ST_START   = 3'd0,
		ST_ZERO    = 3'd1,
		ST_INT     = 3'd2,
		ST_FLOAT   = 3'd3,
		ST_PREEXP  = 3'd4,
		ST_SPREEXP = 3'd5,
		ST_EXP     = 3'd6
	} lex_state_t;

	typedef enum logic [1:0] {
		KIND_INT      = 2'd0,
		KIND_FLOAT    = 2'd1,
		KIND_INTEXP   = 2'd2,
		KIND_FLOATEXP = 2'd3
	} kind_t;

	// Recognizer context carried from one character to the next.
	typedef struct packed {
		lex_state_t st;
		kind_t      kind;
		logic       complete;
	} lex_ctx_t;

	// One result word.
	typedef struct packed {
		logic       accepted;
		logic [1:0] emit_count;
		logic [7:0] emit_first;
		logic [7:0] emit_second;
		logic       replace_lead;
		logic       token_end;
		logic [1:0] token_type;
		logic       token_ok;
	} lex_res_t;

	localparam lex_ctx_t CTX_RESET = '{st: ST_START, kind: KIND_INT, complete: 1'b1};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_exp_mark(input logic [7:0] c);
		return (c == CH_LOW_E) || (c == CH_UP_E);
	endfunction

endpackage

// ===== src/nll_step.sv =====
module nll_step (
	input  logic [7:0]       in_char,
	input  nll_pkg::lex_ctx_t ctx,
	output nll_pkg::lex_ctx_t ctx_nxt,
	output nll_pkg::lex_res_t res
);
	import nll_pkg::*;

	lex_ctx_t   work;
	logic       take;
	logic [1:0] n;
	logic [7:0] e1;
	logic [7:0] e2;
	logic       repl;

	// One transition of the recognizer, with the normalized text it emits.
	always_comb begin
		work = ctx;
		take = 1'b1;
		n    = 2'd0;
		e1   = 8'd0;
		e2   = 8'd0;
		repl = 1'b0;
		case (ctx.st)
			ST_ZERO: begin
				if (in_char == CH_ZERO) begin
					// A further leading zero is dropped.
				end else if (is_digit(in_char)) begin
					n = 2'd1; e1 = in_char; repl = 1'b1; work.st = ST_INT;
				end else if (in_char == CH_DOT) begin
					n = 2'd1; e1 = in_char; work.st = ST_FLOAT; work.kind = KIND_FLOAT;
				end else if (is_exp_mark(in_char)) begin
					n = 2'd1; e1 = CH_UP_E; work.st = ST_PREEXP; work.kind = KIND_INTEXP;
				end else begin
					take = 1'b0;
				end
			end
			ST_INT: begin
				if (is_digit(in_char)) begin
					n = 2'd1; e1 = in_char;
				end else if (in_char == CH_DOT) begin
					n = 2'd1; e1 = in_char; work.st = ST_FLOAT; work.kind = KIND_FLOAT;
				end else if (is_exp_mark(in_char)) begin
					n = 2'd1; e1 = CH_UP_E; work.st = ST_PREEXP; work.kind = KIND_INTEXP;
				end else begin
					take = 1'b0;
				end
			end
			ST_FLOAT: begin
				if (is_digit(in_char)) begin
					n = 2'd1; e1 = in_char;
				end else if (is_exp_mark(in_char)) begin
					n = 2'd1; e1 = CH_UP_E; work.st = ST_PREEXP; work.kind = KIND_FLOATEXP;
				end else begin
					take = 1'b0;
				end
			end
			ST_PREEXP: begin
				work.complete = 1'b0;
				if (in_char == CH_ZERO) begin
					n = 2'd2; e1 = CH_PLUS; e2 = CH_ZERO; work.st = ST_SPREEXP;
				end else if (is_digit(in_char)) begin
					n = 2'd2; e1 = CH_PLUS; e2 = in_char; work.st = ST_EXP;
				end else if ((in_char == CH_PLUS) || (in_char == CH_MINUS)) begin
					n = 2'd1; e1 = in_char; work.st = ST_SPREEXP;
				end else begin
					take = 1'b0;
				end
			end
			ST_SPREEXP: begin
				work.complete = 1'b0;
				if (in_char == CH_ZERO) begin
					// Leading exponent zeros are dropped.
				end else if (is_digit(in_char)) begin
					n = 2'd1; e1 = in_char; work.st = ST_EXP;
				end else begin
					take = 1'b0;
				end
			end
			ST_EXP: begin
				work.complete = 1'b1;
				if (is_digit(in_char)) begin
					n = 2'd1; e1 = in_char;
				end else begin
					take = 1'b0;
				end
			end
			default: begin
				work.kind = KIND_INT;
				if (in_char == CH_ZERO) begin
					n = 2'd1; e1 = in_char; work.st = ST_ZERO;
				end else if (is_digit(in_char)) begin
					n = 2'd1; e1 = in_char; work.st = ST_INT;
				end else begin
					work.complete = 1'b0;
					take = 1'b0;
				end
			end
		endcase

		res = '0;
		if (take) begin
			res.accepted     = 1'b1;
			res.emit_count   = n;
			res.emit_first   = e1;
			res.emit_second  = e2;
			res.replace_lead = repl;
			ctx_nxt          = work;
		end else begin
			res.token_end  = 1'b1;
			res.token_type = work.kind;
			res.token_ok   = work.complete;
			ctx_nxt        = CTX_RESET;
		end
	end

endmodule

// ===== src/numeric_literal_lexer.sv =====
// Numeric literal lexer. Feed the text one character per word; each
// character yields exactly one result word. A character that belongs to the
// number comes back with accepted set and 0 to 2 normalized characters to
// append (leading zeros collapse to one '0' that a later nonzero digit
// replaces, flagged by replace_lead; 'e' becomes 'E'; an unsigned exponent
// gets '+'; leading exponent zeros are dropped but for the first one of an
// unsigned exponent). The first character that does not fit comes back with
// token_end set, the token type and token_ok, and is not consumed: present
// it again if it should start the next token. An exponent that is missing
// or made only of zeros gives token_ok low. Throughput is one character per
// clock when the consumer does not stall. The recognizer state register and
// its single-step transition logic form the only feedback loop. Both
// channels use valid/stall; while a finished result still waits for the
// consumer, a new character is taken only if the input register is empty.
module numeric_literal_lexer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] in_char,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       accepted,
	output logic [1:0] emit_count,
	output logic [7:0] emit_first,
	output logic [7:0] emit_second,
	output logic       replace_lead,
	output logic       token_end,
	output logic [1:0] token_type,
	output logic       token_ok
);
	import nll_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       valid_s2;
	lex_res_t   res_s2;
	lex_ctx_t   ctx_q;
	lex_ctx_t   ctx_nxt;
	lex_res_t   res_nxt;
	logic       adv_s2;
	logic       adv_s1;

	// The result register can load when it is empty or being drained. The
	// input register moves forward whenever its character can be processed.
	assign adv_s2     = !valid_s2 || !result_stall;
	assign adv_s1     = valid_s1 && adv_s2;
	assign item_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			char_s1 <= in_char;
		end
	end

	nll_step u_step (
		.in_char (char_s1),
		.ctx     (ctx_q),
		.ctx_nxt (ctx_nxt),
		.res     (res_nxt)
	);

	// The recognizer context advances exactly when a character is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q    <= CTX_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				ctx_q <= ctx_nxt;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign accepted     = res_s2.accepted;
	assign emit_count   = res_s2.emit_count;
	assign emit_first   = res_s2.emit_first;
	assign emit_second  = res_s2.emit_second;
	assign replace_lead = res_s2.replace_lead;
	assign token_end    = res_s2.token_end;
	assign token_type   = res_s2.token_type;
	assign token_ok     = res_s2.token_ok;

endmodule
